[src/rken_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rken_pkg: shared types and constants
// widths, register indexes and the queue entry for the error norm block
// ----------------------------------------------------------------------------
package rken_pkg;

    localparam int MaxEquations = 1024;
    localparam int CntW = $clog2(MaxEquations + 1);

    typedef enum logic [1:0] {
        REG_REL_TOL = 2'd0,
        REG_ABS_TOL = 2'd1,
        REG_STEP    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] y_old;
        logic signed [31:0] y_new;
        logic signed [31:0] slope_old;
        logic signed [31:0] stage_two;
        logic signed [31:0] stage_three;
        logic signed [31:0] stage_four;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [31:0]     error_norm;
        logic [CntW-1:0] element_count;
        logic            saturated;
    } t_out_item;

    // classified item handed from the front to the back
    typedef struct packed {
        logic [35:0] sum_mag;
        logic [63:0] scale;
        logic        skip;
        logic        last;
    } t_job;

endpackage

[src/rken_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rken_in_if / rken_out_if / rken_cfg_if: handshake channels
// valid and ready with the payload of each channel
// ----------------------------------------------------------------------------
interface rken_in_if;
    import rken_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rken_out_if;
    import rken_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rken_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

[src/rken_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rken_front: item intake
// forms weighted stage sum magnitude and the Q16.48 scale, registered
// ----------------------------------------------------------------------------
module rken_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rken_in_if.sink           in_ch,
    input  logic [31:0]       i_rel_tol,
    input  logic [31:0]       i_abs_tol,
    output logic              o_valid,
    output rken_pkg::t_job    o_job,
    input  logic              i_ready
);
    import rken_pkg::*;

    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] n_cnt;
    logic            r_valid;
    t_job            r_job;
    logic [32:0]     w_my, w_mn, w_mx;
    logic signed [36:0] w_s;
    logic            w_take;

    assign in_ch.ready = !r_valid || i_ready;
    assign w_take = in_ch.valid && in_ch.ready;

    always_comb begin
        w_my = in_ch.data.y_old[31] ? 33'(-$signed({in_ch.data.y_old[31], in_ch.data.y_old}))
                                    : 33'({1'b0, in_ch.data.y_old});
        w_mn = in_ch.data.y_new[31] ? 33'(-$signed({in_ch.data.y_new[31], in_ch.data.y_new}))
                                    : 33'({1'b0, in_ch.data.y_new});
        w_mx = (w_my > w_mn) ? w_my : w_mn;
        w_s = 37'sd5 * 37'(in_ch.data.slope_old) - 37'sd6 * 37'(in_ch.data.stage_two)
            - 37'sd8 * 37'(in_ch.data.stage_three) + 37'sd9 * 37'(in_ch.data.stage_four);
        n_cnt = r_cnt;
        if (w_take) begin
            if (in_ch.data.last) n_cnt = '0;
            else if (r_cnt < CntW'(MaxEquations)) n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_take) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
        if (w_take) begin
            r_job.sum_mag <= w_s[36] ? 36'(-w_s) : 36'(w_s);
            r_job.scale   <= {16'd0, i_abs_tol, 16'd0} + 64'(i_rel_tol) * 64'(w_mx);
            r_job.skip    <= r_cnt >= CntW'(MaxEquations);
            r_job.last    <= in_ch.data.last;
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
endmodule

[src/rken_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rken_queue: two-entry job queue
// decouples intake from the sequential back end
// ----------------------------------------------------------------------------
module rken_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rken_pkg::t_job i_job,
    output logic           o_ready,
    output logic           o_valid,
    output rken_pkg::t_job o_job,
    input  logic           i_ready
);
    import rken_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_fill;
    logic       w_push, w_pop;

    assign o_ready = r_fill != 2'd2;
    assign o_valid = r_fill != 2'd0;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_fill <= '0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_fill <= r_fill + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wp] <= i_job;
    end
endmodule

[src/rken_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rken_back: ratio, accumulate and norm
// restoring divider one bit a cycle, mean by a separate bit-serial divider, bitwise sqrt
// ----------------------------------------------------------------------------
module rken_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rken_pkg::t_job i_job,
    output logic           o_ready,
    input  logic [30:0]    i_step,
    rken_out_if.source     out_ch
);
    import rken_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_MUL  = 8'b00000010,
        S_CHK  = 8'b00000100,
        S_DIV  = 8'b00001000,
        S_SQR  = 8'b00010000,
        S_ACC  = 8'b00100000,
        S_MEAN = 8'b01000000,
        S_ROOT = 8'b10000000
    } t_state;

    t_state          r_st;
    t_job            r_job;
    logic [66:0]     r_prod;
    logic [127:0]    r_rem;
    logic [69:0]     r_den;
    logic [31:0]     r_q;
    logic [5:0]      r_bit;
    logic [63:0]     r_sq;
    logic [63:0]     r_sum;
    logic [CntW-1:0] r_cnt;
    logic            r_sat;
    logic [63:0]     r_mrem;
    logic [63:0]     r_mean;
    logic [63:0]     r_res;
    logic [63:0]     r_sbit;
    logic            r_ov;
    t_out_item       r_out;
    logic [CntW-1:0] w_cnt1;
    logic [100:0]    w_dsh;
    logic [64:0]     w_madd;
    logic [63:0]     w_rt;

    assign o_ready = r_st == S_IDLE;
    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_out;
    assign w_cnt1 = (r_cnt == '0) ? CntW'(1) : r_cnt;

    always_comb begin
        w_dsh  = 101'(r_den) << r_bit[4:0];
        w_madd = 65'(r_sum) + 65'(r_sq);
        w_rt   = r_res + r_sbit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0;
            r_sum <= '0; r_cnt <= '0; r_sat <= 1'b0;
        end else begin
            if (r_ov && out_ch.ready) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_valid) begin
                    r_job <= i_job;
                    r_st  <= i_job.skip ? S_ACC : S_MUL;
                    r_sq  <= '0;
                    if (i_job.skip) r_sat <= 1'b1;
                end
                S_MUL: begin
                    r_prod <= 67'(i_step) * 67'(r_job.sum_mag);
                    r_den  <= 70'(r_job.scale) * 70'd72;
                    r_st   <= S_CHK;
                end
                S_CHK: begin
                    r_q <= '0;
                    r_bit <= 6'd31;
                    r_rem <= {29'd0, r_prod, 32'd0};
                    if (r_job.scale == '0) begin
                        r_sq <= 64'(32'hFFFF_FFFF) * 64'(32'hFFFF_FFFF);
                        r_sat <= 1'b1; r_st <= S_ACC;
                    end else if (r_prod == '0) begin
                        r_st <= S_ACC;
                    end else if ({29'd0, r_prod, 32'd0} >= {26'd0, r_den, 32'd0}) begin
                        r_sq <= 64'(32'hFFFF_FFFF) * 64'(32'hFFFF_FFFF);
                        r_sat <= 1'b1; r_st <= S_ACC;
                    end else r_st <= S_DIV;
                end
                S_DIV: begin
                    if (r_rem >= 128'(w_dsh)) begin
                        r_rem <= r_rem - 128'(w_dsh);
                        r_q[r_bit[4:0]] <= 1'b1;
                    end
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) r_st <= S_SQR;
                end
                S_SQR: begin
                    r_sq <= 64'(r_q) * 64'(r_q);
                    r_st <= S_ACC;
                end
                S_ACC: begin
                    if (!r_job.skip) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (w_madd[64]) begin
                            r_sum <= '1; r_sat <= 1'b1;
                        end else r_sum <= w_madd[63:0];
                    end
                    if (r_job.last) begin
                        r_mrem <= '0; r_mean <= '0; r_bit <= 6'd63;
                        r_st <= S_MEAN;
                    end else r_st <= S_IDLE;
                end
                S_MEAN: begin
                    if ({r_mrem[62:0], r_sum[r_bit]} >= 64'(w_cnt1)) begin
                        r_mrem <= {r_mrem[62:0], r_sum[r_bit]} - 64'(w_cnt1);
                        r_mean[r_bit] <= 1'b1;
                    end else r_mrem <= {r_mrem[62:0], r_sum[r_bit]};
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        r_res <= '0; r_sbit <= 64'd1 << 62; r_st <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    // last step waits while the previous result is still held
                    if (!(r_sbit == 64'd1 && r_ov)) begin
                        if (r_mean >= w_rt) begin
                            r_mean <= r_mean - w_rt;
                            r_res  <= (r_res >> 1) + r_sbit;
                        end else r_res <= r_res >> 1;
                        r_sbit <= r_sbit >> 2;
                        if (r_sbit == 64'd1) begin
                            r_ov <= 1'b1;
                            r_out.error_norm <= (r_mean >= w_rt) ?
                                                32'((r_res >> 1) + r_sbit) :
                                                32'(r_res >> 1);
                            r_out.element_count <= r_cnt;
                            r_out.saturated <= r_sat;
                            r_sum <= '0; r_cnt <= '0; r_sat <= 1'b0;
                            r_st <= S_IDLE;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

[src/rk_error_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rk_error_norm: RK23 weighted RMS error norm
// streams one equation per transfer, one norm result per vector
// ----------------------------------------------------------------------------
// The back end works one item at a time: a multiply, then a 32-step restoring
// divider forms the ratio of embedded error to scale, then a square and an add.
// A last item adds a bit-serial mean division and a square root. The front
// end registers scale and stage sum and a two-entry queue lets it run ahead.
module rk_error_norm (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rken_in_if.sink    in_ch,
    rken_out_if.source out_ch,
    rken_cfg_if.sink   cfg_ch
);
    import rken_pkg::*;

    logic [31:0] r_rel, r_abs;
    logic [30:0] r_step;
    logic        w_fv, w_fr, w_qv, w_qr;
    t_job        w_fj, w_qj;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rel <= 32'd4295; r_abs <= 32'd4295; r_step <= 31'd65536;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.index)
                REG_REL_TOL: r_rel  <= cfg_ch.wdata;
                REG_ABS_TOL: r_abs  <= cfg_ch.wdata;
                REG_STEP:    r_step <= cfg_ch.wdata[30:0];
                default: ;
            endcase
        end
    end

    rken_front u_front (.i_clk, .i_rst_n, .in_ch, .i_rel_tol(r_rel), .i_abs_tol(r_abs),
                        .o_valid(w_fv), .o_job(w_fj), .i_ready(w_fr));
    rken_queue u_queue (.i_clk, .i_rst_n, .i_valid(w_fv), .i_job(w_fj), .o_ready(w_fr),
                        .o_valid(w_qv), .o_job(w_qj), .i_ready(w_qr));
    rken_back  u_back  (.i_clk, .i_rst_n, .i_valid(w_qv), .i_job(w_qj), .o_ready(w_qr),
                        .i_step(r_step), .out_ch);
endmodule

[src/rken_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rken_port_checks: port checks
// result and handshake properties seen at the top level
// ----------------------------------------------------------------------------
module rken_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [10:0] out_count,
    input logic        cfg_ready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_count)) else $error("out hold");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_count <= 11'd1024) else $error("count range");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_ready) else $error("cfg ready");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid) else $error("reset valid");
endmodule

bind rk_error_norm rken_port_checks u_chk (.i_clk, .i_rst_n, .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .out_count(out_ch.data.element_count), .cfg_ready(cfg_ch.ready));

[dv/rken_tb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rken_tb_if: testbench package beside the handshake channels
// the block's own channel interfaces are reused; this file adds only the
// package rken_tb_pkg, whose struct t_norm_exp is the only type that is new
// ----------------------------------------------------------------------------
package rken_tb_pkg;
    import rken_pkg::*;

    // one expected norm result
    typedef struct packed {
        logic [31:0]     error_norm;
        logic [CntW-1:0] element_count;
        logic            saturated;
    } t_norm_exp;
endpackage

[dv/rken_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rken_checker: norm predictor and result scoreboard
// watches the config, input and output channels, predicts each vector norm
// and compares every output transfer field by field with the oldest prediction
// ----------------------------------------------------------------------------
module rken_checker
    import rken_pkg::*;
    import rken_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rken_in_if          in_ch,
    rken_out_if         out_ch,
    rken_cfg_if         cfg_ch,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_norm_count
);

    logic [31:0]  rel_tol;
    logic [31:0]  abs_tol;
    logic [30:0]  step_q16;
    logic [63:0]  sq_sum;
    int unsigned  held;
    logic         sat_seen;
    t_norm_exp    norm_q[$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    function automatic logic [31:0] ratio_q16(input logic [63:0] mag,
                                              input logic [63:0] scale,
                                              output logic sat);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        sat = 1'b0;
        if (scale == 0) begin
            sat = 1'b1;
            return 32'hFFFF_FFFF;
        end
        if (mag == 0 || step_q16 == 0) return 32'd0;
        num = (128'(step_q16) * 128'(mag)) << 32;
        den = 128'(scale) * 128'd72;
        q = num / den;
        if (q >= 128'h1_0000_0000) begin
            sat = 1'b1;
            return 32'hFFFF_FFFF;
        end
        return q[31:0];
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic predict_item(input t_in_item it);
        logic [63:0] my;
        logic [63:0] mn;
        logic [63:0] mx;
        logic [63:0] scale;
        logic signed [63:0] s;
        logic [31:0] r;
        logic [63:0] sq;
        logic sat;
        logic [64:0] acc;
        logic [63:0] rt;
        t_norm_exp e;
        if (held >= MaxEquations) begin
            sat_seen = 1'b1;
        end else begin
            my = it.y_old < 0 ? 64'(-64'(it.y_old)) : 64'(it.y_old);
            mn = it.y_new < 0 ? 64'(-64'(it.y_new)) : 64'(it.y_new);
            mx = my > mn ? my : mn;
            scale = (64'(abs_tol) << 16) + 64'(rel_tol) * mx;
            s = 5 * 64'(it.slope_old) - 6 * 64'(it.stage_two)
                - 8 * 64'(it.stage_three) + 9 * 64'(it.stage_four);
            r = ratio_q16(s < 0 ? -s : s, scale, sat);
            sq = 64'(r) * 64'(r);
            if (sat) sat_seen = 1'b1;
            acc = 65'(sq_sum) + 65'(sq);
            if (acc[64]) begin
                sq_sum = '1;
                sat_seen = 1'b1;
            end else begin
                sq_sum = acc[63:0];
            end
            held++;
        end
        if (it.last) begin
            rt = root64(sq_sum / (held ? held : 1));
            e.error_norm = rt[31:0];
            e.element_count = held[CntW-1:0];
            e.saturated = sat_seen;
            norm_q.push_back(e);
            sq_sum = 0;
            held = 0;
            sat_seen = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_norm_exp e;
        if (!i_rst_n) begin
            rel_tol <= 32'd4295;
            abs_tol <= 32'd4295;
            step_q16 <= 31'd65536;
            sq_sum = 0;
            held = 0;
            sat_seen = 1'b0;
            norm_q.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_REL_TOL: rel_tol <= cfg_ch.wdata;
                    REG_ABS_TOL: abs_tol <= cfg_ch.wdata;
                    REG_STEP:    step_q16 <= cfg_ch.wdata[30:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) predict_item(in_ch.data);
            if (out_ch.valid && out_ch.ready) begin
                o_norm_count++;
                if (norm_q.size() == 0) begin
                    report("unexpected result", 64'(out_ch.data), 0);
                end else begin
                    e = norm_q.pop_front();
                    if (out_ch.data.error_norm !== e.error_norm)
                        report("error_norm", out_ch.data.error_norm, e.error_norm);
                    if (out_ch.data.element_count !== e.element_count)
                        report("element_count", out_ch.data.element_count,
                               e.element_count);
                    if (out_ch.data.saturated !== e.saturated)
                        report("saturated", out_ch.data.saturated, e.saturated);
                end
            end
        end
        o_pending = norm_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_norm_count = 0;
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: error norm block stimulus and verdict
// directed corner vectors, then random vectors under several tolerance and
// step settings with random gaps and a long output stall
// ----------------------------------------------------------------------------
module testbench;
    import rken_pkg::*;

    localparam int CycleLimit = 2_000_000;

    logic i_clk;
    logic i_rst_n;
    int   cycles;
    int   fail_count;
    int   pending;
    int   norm_count;
    int   items_sent;
    bit   hold_off;

    rken_in_if  in_ch ();
    rken_out_if out_ch ();
    rken_cfg_if cfg_ch ();

    rk_error_norm u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch)
    );

    rken_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_norm_count (norm_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    // output side: random stalls, one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    function automatic logic [31:0] rand_val(input int mode);
        case (mode)
            0: return $urandom_range(0, 2) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
            default: return $urandom();
        endcase
    endfunction

    // valid stays high into the next transfer when there is no gap
    task automatic send_item(input t_in_item it);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_ch.data <= it;
        in_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_rand(input int mode, input logic last);
        t_in_item it;
        it.y_old = rand_val(mode);
        it.y_new = rand_val(mode);
        it.slope_old = rand_val(mode);
        it.stage_two = rand_val(mode);
        it.stage_three = rand_val(mode);
        it.stage_four = rand_val(mode);
        it.last = last;
        send_item(it);
    endtask

    task automatic send_fields(input logic [31:0] a, input logic [31:0] b,
                               input logic [31:0] c, input logic [31:0] d,
                               input logic [31:0] e, input logic [31:0] f,
                               input logic last);
        t_in_item it;
        it = '{a, b, c, d, e, f, last};
        send_item(it);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] v);
        @(negedge i_clk);
        cfg_ch.index <= idx;
        cfg_ch.wdata <= v;
        cfg_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [31:0] rel, input logic [31:0] abst,
                            input logic [31:0] stp);
        write_reg(REG_REL_TOL, rel);
        write_reg(REG_ABS_TOL, abst);
        write_reg(REG_STEP, stp);
    endtask

    task automatic random_phase(input int n);
        int len;
        int k;
        int mode;
        k = 0;
        while (k < n) begin
            len = $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 6);
            mode = $urandom_range(0, 5);
            for (int j = 0; j < len; j++) send_rand(mode > 3 ? 3 : mode, j == len - 1);
            k += len;
        end
    endtask

    initial begin
        cycles = 0;
        items_sent = 0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_REL_TOL;
        cfg_ch.wdata = '0;
        out_ch.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset settings, zero error, extremes, single-item and two-item vectors
        send_fields(0, 0, 0, 0, 0, 0, 1'b1);
        send_fields(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_fields(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0100, 32'h0, 32'h0,
                    32'h0, 1'b0);
        send_fields(32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        drain();
        // zero scale: both tolerances zero, with zero and nonzero error
        set_regs(32'h0, 32'h0, 32'h0001_0000);
        send_fields(0, 0, 0, 0, 0, 0, 1'b0);
        send_fields(5, 7, 32'h10, 0, 0, 0, 1'b1);
        drain();
        // extreme registers, step zero, and maximum step
        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_fields(32'h1234, 32'h5678, 32'h7FFF_FFFF, 0, 0, 0, 1'b1);
        drain();
        set_regs(32'h1, 32'h1, 32'hFFFF_FFFF);
        send_fields(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 1'b0);
        send_fields(0, 0, 32'h0000_0001, 0, 0, 0, 1'b1);
        drain();
        // sum overflow and an over-long vector
        set_regs(32'h0, 32'h1, 32'h7FFF_FFFF);
        for (int j = 0; j < 1030; j++)
            send_fields(0, 0, 32'h7FFF_FFFF, 0, 0, 0, j == 1029);
        drain();

        // random phases through several settings
        set_regs(32'd4295, 32'd4295, 32'h0001_0000);
        random_phase(200);
        drain();
        set_regs($urandom(), $urandom(), $urandom());
        random_phase(150);
        drain();
        set_regs(32'h0010_0000, 32'h0100_0000, 32'h0000_0400);
        // long output stall while input keeps offering items
        fork
            begin
                @(negedge i_clk);
                hold_off = 1'b1;
                repeat (3000) @(posedge i_clk);
                @(negedge i_clk);
                hold_off = 1'b0;
            end
            random_phase(60);
        join
        random_phase(140);
        drain();
        set_regs(32'hFFFF_FFFF, 32'h0, 32'h0000_0001);
        random_phase(180);
        drain();
        set_regs(32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        random_phase(180);
        drain();

        $display("sent %0d equations, checked %0d norm results", items_sent, norm_count);
        $display("covered zero scale, ratio and sum saturation, over-long vectors");
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
